@@ sv/brbm_pkg.sv @@
// ----------------------------------------------------------------------------
// brbm_pkg - shared definitions for the boot ROM bank mapper
// Outcome codes, memory map constants, register indexes and the
// request type that passes between the mapper and its work RAM.
// ----------------------------------------------------------------------------
package brbm_pkg;

	// Default size of the work RAM in bytes
	localparam int DEF_RAM_BYTES = 8192;

	// Memory map geometry
	localparam int PAGE_BYTES   = 16384;
	localparam int FIXED_BYTES  = 1024;
	localparam int WINDOW_BYTES = 16384;
	localparam int WINDOW_AW    = 14;
	localparam int RAM_AW_MAX   = 14;

	// Field widths
	localparam int ADDR_W    = 16;
	localparam int DATA_W    = 8;
	localparam int OUTCOME_W = 3;
	localparam int ROM_AW    = 22;
	localparam int BANK_W    = 8;
	localparam int CFG_AW    = 4;
	localparam int CFG_DW    = 32;

	// Address boundaries
	localparam logic [ADDR_W-1:0] ADDR_RAM_BASE = 16'hC000;
	localparam logic [ADDR_W-1:0] ADDR_BANK0    = 16'hFFFD;

	// Access kinds
	localparam logic KIND_READ  = 1'b0;
	localparam logic KIND_WRITE = 1'b1;

	// Outcome codes
	localparam logic [OUTCOME_W-1:0] OUT_NO_ROM     = 3'd0;
	localparam logic [OUTCOME_W-1:0] OUT_FIXED_ROM  = 3'd1;
	localparam logic [OUTCOME_W-1:0] OUT_BANKED_ROM = 3'd2;
	localparam logic [OUTCOME_W-1:0] OUT_RAM_READ   = 3'd3;
	localparam logic [OUTCOME_W-1:0] OUT_WR_IGNORED = 3'd4;
	localparam logic [OUTCOME_W-1:0] OUT_ROM_REJECT = 3'd5;
	localparam logic [OUTCOME_W-1:0] OUT_RAM_STORED = 3'd6;
	localparam logic [OUTCOME_W-1:0] OUT_BANK_LOAD  = 3'd7;

	// Configuration register indexes (paddr[3:2])
	localparam logic [1:0] REG_BOOTROM_PRESENT = 2'd0;
	localparam logic [1:0] REG_BANKS_FROM_CART = 2'd1;
	localparam logic [1:0] REG_BANK_MASK       = 2'd2;

	// Register reset values
	localparam logic              RST_BOOTROM_PRESENT = 1'b1;
	localparam logic              RST_BANKS_FROM_CART = 1'b0;
	localparam logic [BANK_W-1:0] RST_BANK_MASK       = 8'd15;

	// Work RAM request
	typedef struct packed {
		logic                  we;
		logic                  re;
		logic [RAM_AW_MAX-1:0] idx;
		logic [DATA_W-1:0]     wdata;
	} ram_req_t;

	// One result item
	typedef struct packed {
		logic [OUTCOME_W-1:0] outcome;
		logic                 rom_source;
		logic [ROM_AW-1:0]    rom_address;
	} res_t;

endpackage

@@ sv/brbm_if.sv @@
// ----------------------------------------------------------------------------
// brbm_acc_if / brbm_res_if - request and result channels
// Valid/ready channels carrying one bus access in and one result out.
// ----------------------------------------------------------------------------
interface brbm_acc_if import brbm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              kind;
	logic [ADDR_W-1:0] address;
	logic [DATA_W-1:0] write_data;

	modport source (output valid, kind, address, write_data, input ready);
	modport sink   (input valid, kind, address, write_data, output ready);
endinterface

interface brbm_res_if import brbm_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [OUTCOME_W-1:0] outcome;
	logic                 rom_source;
	logic [ROM_AW-1:0]    rom_address;
	logic [DATA_W-1:0]    ram_data;

	modport source (output valid, outcome, rom_source, rom_address, ram_data, input ready);
	modport sink   (input valid, outcome, rom_source, rom_address, ram_data, output ready);
endinterface

@@ sv/boot_rom_bank_mapper.sv @@
// ----------------------------------------------------------------------------
// boot_rom_bank_mapper - bus access bank mapper for a boot ROM
// Decodes one CPU bus access per request, translates banked ROM reads,
// serves and stores work RAM bytes and loads the bank registers.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake          Payload
//  acc      in   valid/ready        kind, address, write_data
//  res      out  valid/ready        outcome, rom_source, rom_address, ram_data
//  cfg      in   APB, pready tied   bootrom_present, banks_from_cartridge, bank_mask
//
//  One request per cycle unless results stall; each passes the RAM read and output stages.
//  The work RAM port is used once per request, so reads and writes never
//  collide and a read sees every earlier write.
//  After reset the RAM is cleared entry by entry; acc.ready stays low until the sweep ends.
//  A stalled result is held in the output stage; one more request is taken
//  into the RAM read stage behind it before acc.ready drops.
// ----------------------------------------------------------------------------
module boot_rom_bank_mapper import brbm_pkg::*; #(
	parameter int RAM_BYTES = DEF_RAM_BYTES
) (
	input  logic              clk,
	input  logic              arst_n,
	brbm_acc_if.sink          acc,
	brbm_res_if.source        res,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [CFG_DW-1:0] pwdata,
	output logic [CFG_DW-1:0] prdata,
	output logic              pready
);

	localparam int RAM_AW  = $clog2(RAM_BYTES);
	localparam int MIRRORS = (WINDOW_BYTES + RAM_BYTES - 1) / RAM_BYTES;

	// Configuration registers
	logic              bootrom_present_q;
	logic              banks_from_cart_q;
	logic [BANK_W-1:0] bank_mask_q;
	logic [1:0]        cfg_idx;
	logic              cfg_wr;

	// Bank registers
	logic [BANK_W-1:0] bank_q [3];

	// Decode
	res_t              dec;
	ram_req_t          ram_req;
	logic              bank_ld;
	logic [1:0]        bank_ld_idx;
	logic [BANK_W-1:0] bank_sel;
	logic [31:0]       bank_base;
	logic [WINDOW_AW-1:0] win_off;
	logic [WINDOW_AW-1:0] mir_off;
	logic              is_ram;

	// Pipeline
	logic              acc_fire;
	logic              s1_adv;
	logic              valid_s1;
	res_t              res_s1;
	logic              valid_s2;
	res_t              res_s2;
	logic [DATA_W-1:0] ram_data_s2;
	logic [DATA_W-1:0] ram_rd;
	logic              clr_busy;

	// APB write and read-back
	assign pready  = 1'b1;
	assign cfg_idx = paddr[CFG_AW-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bootrom_present_q <= RST_BOOTROM_PRESENT;
			banks_from_cart_q <= RST_BANKS_FROM_CART;
			bank_mask_q       <= RST_BANK_MASK;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_BOOTROM_PRESENT: bootrom_present_q <= pwdata[0];
				REG_BANKS_FROM_CART: banks_from_cart_q <= pwdata[0];
				REG_BANK_MASK:       bank_mask_q       <= pwdata[BANK_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_BOOTROM_PRESENT: prdata = CFG_DW'(bootrom_present_q);
			REG_BANKS_FROM_CART: prdata = CFG_DW'(banks_from_cart_q);
			REG_BANK_MASK:       prdata = CFG_DW'(bank_mask_q);
			default:             prdata = '0;
		endcase
	end

	// Handshake: take a request when the clearing sweep is over and the RAM read stage is free or moving
	assign s1_adv    = !valid_s2 || res.ready;
	assign acc.ready = !clr_busy && (!valid_s1 || s1_adv);
	assign acc_fire  = acc.valid && acc.ready;

	// Fold the RAM window onto the work RAM
	assign win_off = acc.address[WINDOW_AW-1:0];
	always_comb begin
		mir_off = win_off;
		for (int k = 1; k < MIRRORS; k++) begin
			if (win_off >= WINDOW_AW'(k * RAM_BYTES)) begin
				mir_off = win_off - WINDOW_AW'(k * RAM_BYTES);
			end
		end
	end

	// Banked translation base for the addressed window
	always_comb begin
		unique case (acc.address[ADDR_W-1:ADDR_W-2])
			2'd0:    bank_sel = bank_q[0];
			2'd1:    bank_sel = bank_q[1];
			default: bank_sel = bank_q[2];
		endcase
	end
	assign bank_base = 32'(bank_sel) * 32'(PAGE_BYTES);
	assign is_ram    = acc.address >= ADDR_RAM_BASE;

	// Decode the request into a result and a RAM access
	always_comb begin
		dec           = '0;
		ram_req       = '0;
		ram_req.idx   = RAM_AW_MAX'(mir_off[RAM_AW-1:0]);
		ram_req.wdata = acc.write_data;
		bank_ld       = 1'b0;
		bank_ld_idx   = acc.address[1:0] - 2'd1;
		priority if (!bootrom_present_q) begin
			dec.outcome = (acc.kind == KIND_WRITE) ? OUT_WR_IGNORED : OUT_NO_ROM;
		end else if (acc.kind == KIND_READ) begin
			if (is_ram) begin
				dec.outcome = OUT_RAM_READ;
				ram_req.re  = acc_fire;
			end else if (acc.address[ADDR_W-1:ADDR_W-2] == 2'd0 &&
					{1'b0, acc.address} < 17'(FIXED_BYTES)) begin
				dec.outcome     = OUT_FIXED_ROM;
				dec.rom_address = ROM_AW'(acc.address);
			end else begin
				dec.outcome     = OUT_BANKED_ROM;
				dec.rom_source  = banks_from_cart_q;
				dec.rom_address = bank_base[ROM_AW-1:0] + ROM_AW'(win_off);
			end
		end else begin
			if (!is_ram) begin
				dec.outcome = OUT_ROM_REJECT;
			end else begin
				ram_req.we = acc_fire;
				if (acc.address >= ADDR_BANK0) begin
					dec.outcome = OUT_BANK_LOAD;
					bank_ld     = acc_fire;
				end else begin
					dec.outcome = OUT_RAM_STORED;
				end
			end
		end
	end

	// Load a bank register with the masked byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q[0] <= 8'd0;
			bank_q[1] <= 8'd1;
			bank_q[2] <= 8'd2;
		end else if (bank_ld) begin
			unique case (bank_ld_idx)
				2'd0:    bank_q[0] <= acc.write_data & bank_mask_q;
				2'd1:    bank_q[1] <= acc.write_data & bank_mask_q;
				2'd2:    bank_q[2] <= acc.write_data & bank_mask_q;
				default: ;
			endcase
		end
	end

	brbm_ram #(
		.RAM_BYTES(RAM_BYTES)
	) u_ram (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (ram_req),
		.rd_data  (ram_rd),
		.clr_busy (clr_busy)
	);

	// Advance the valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!valid_s1 || s1_adv) begin
				valid_s1 <= acc_fire;
			end
			if (s1_adv) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Hold the payload of each stage
	always_ff @(posedge clk) begin
		if (acc_fire) begin
			res_s1 <= dec;
		end
		if (s1_adv && valid_s1) begin
			res_s2      <= res_s1;
			ram_data_s2 <= (res_s1.outcome == OUT_RAM_READ) ? ram_rd : '0;
		end
	end

	assign res.valid       = valid_s2;
	assign res.outcome     = res_s2.outcome;
	assign res.rom_source  = res_s2.rom_source;
	assign res.rom_address = res_s2.rom_address;
	assign res.ram_data    = ram_data_s2;

	// RAM read data must hold while the read stage is stalled
	a_rd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_adv) |=> $stable(ram_rd))
		else $error("RAM read data changed under a stalled request");

	// RAM byte only on a RAM read
	a_ram_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.outcome != OUT_RAM_READ) |-> (res.ram_data == '0))
		else $error("RAM byte on a result that is not a RAM read");

	// ROM address only for ROM reads
	a_rom_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.outcome != OUT_FIXED_ROM && res.outcome != OUT_BANKED_ROM)
		|-> (res.rom_address == '0 && !res.rom_source))
		else $error("ROM address on a result that is not a ROM read");

endmodule

@@ sv/brbm_ram.sv @@
// ----------------------------------------------------------------------------
// brbm_ram - work RAM with registered read and clearing sweep
// Single-port synchronous RAM. After reset it writes zero to every
// entry, one a cycle, and reports busy until the sweep ends.
// ----------------------------------------------------------------------------
module brbm_ram import brbm_pkg::*; #(
	parameter int RAM_BYTES = DEF_RAM_BYTES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ram_req_t          req,
	output logic [DATA_W-1:0] rd_data,
	output logic              clr_busy
);

	localparam int RAM_AW = $clog2(RAM_BYTES);

	logic [DATA_W-1:0] mem [RAM_BYTES];
	logic [DATA_W-1:0] rd_q;
	logic [RAM_AW-1:0] clr_idx_q;
	logic              clr_busy_q;

	// Sweep the array once after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q  <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + RAM_AW'(1);
			if (clr_idx_q == RAM_AW'(RAM_BYTES - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// Write the sweep or a request; the read is registered
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_idx_q] <= '0;
		end else if (req.we) begin
			mem[req.idx[RAM_AW-1:0]] <= req.wdata;
		end
		if (req.re) begin
			rd_q <= mem[req.idx[RAM_AW-1:0]];
		end
	end

	assign rd_data  = rd_q;
	assign clr_busy = clr_busy_q;

	// No access may overlap the clearing sweep
	a_no_access_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(req.we || req.re) |-> !clr_busy_q)
		else $error("work RAM accessed during clearing sweep");

	// One port: read and write never together
	a_single_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.we && req.re))
		else $error("work RAM read and write in the same cycle");

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - self-checking bench for the boot ROM bank mapper
// Drives bus access requests through the valid/ready channel and configures
// the mapper over APB between phases. A behavioural model of the bank
// registers and work RAM predicts every result, and each result is compared
// field by field. Both channels idle at random, and the result side holds off
// for a long stretch once so that the mapper fills and stalls its input.
// ----------------------------------------------------------------------------
module testbench;
	import brbm_pkg::*;

	localparam int  RAM_SIZE      = DEF_RAM_BYTES;
	localparam int  CYCLE_LIMIT   = 1000000;
	localparam int  SETTLE_CYCLES = 8;
	localparam int  LONG_HOLD     = 200;
	localparam int  MAX_REPORTS   = 30;

	typedef struct packed {
		logic [OUTCOME_W-1:0] outcome;
		logic                 rom_source;
		logic [ROM_AW-1:0]    rom_address;
		logic [DATA_W-1:0]    ram_data;
	} access_result_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [CFG_AW-1:0] paddr;
	logic [CFG_DW-1:0] pwdata;
	logic [CFG_DW-1:0] prdata;
	logic              pready;

	brbm_acc_if acc_bus ();
	brbm_res_if res_bus ();

	// Mapper image: configuration, bank registers and work RAM
	logic              rom_on;
	logic              from_cart;
	logic [BANK_W-1:0] mask_image;
	logic [BANK_W-1:0] bank_image [3];
	logic [DATA_W-1:0] ram_image [RAM_SIZE];

	access_result_t pending_results [$];
	int             failures;
	int             cycle_count;
	bit             tx_idle;
	bit             rx_idle;
	bit             stall_request;

	boot_rom_bank_mapper #(
		.RAM_BYTES (RAM_SIZE)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.acc     (acc_bus),
		.res     (res_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Work out the result of one access and update the image
	function automatic access_result_t predict_access(input logic kind,
			input logic [ADDR_W-1:0] address, input logic [DATA_W-1:0] data);
		access_result_t r;
		int             window;
		int             ram_idx;
		int             rom_full;
		r        = '0;
		window   = int'(address[15:14]);
		ram_idx  = (int'(address) - int'(ADDR_RAM_BASE)) % RAM_SIZE;
		rom_full = int'(bank_image[window % 3]) * PAGE_BYTES + int'(address[13:0]);
		if (!rom_on) begin
			r.outcome = (kind == KIND_WRITE) ? OUT_WR_IGNORED : OUT_NO_ROM;
		end else if (kind == KIND_READ) begin
			if (address >= ADDR_RAM_BASE) begin
				r.outcome  = OUT_RAM_READ;
				r.ram_data = ram_image[ram_idx];
			end else if (window == 0 && int'(address) < FIXED_BYTES) begin
				r.outcome     = OUT_FIXED_ROM;
				r.rom_address = ROM_AW'(address);
			end else begin
				r.outcome     = OUT_BANKED_ROM;
				r.rom_source  = from_cart;
				r.rom_address = rom_full[ROM_AW-1:0];
			end
		end else if (address < ADDR_RAM_BASE) begin
			r.outcome = OUT_ROM_REJECT;
		end else begin
			// The whole byte lands in RAM, the masked copy in the bank register
			ram_image[ram_idx] = data;
			if (address >= ADDR_BANK0) begin
				bank_image[int'(address - ADDR_BANK0)] = data & mask_image;
				r.outcome = OUT_BANK_LOAD;
			end else begin
				r.outcome = OUT_RAM_STORED;
			end
		end
		return r;
	endfunction

	function automatic int pick_gap();
		return ($urandom_range(0, 11) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
	endfunction

	task automatic report_mismatch(input string field, input int want, input int got);
		failures++;
		if (failures <= MAX_REPORTS)
			$display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, field, want, got);
	endtask

	// Check each result, then predict each accepted request
	always @(posedge clk) begin
		access_result_t want;
		if (arst_n) begin
			if (res_bus.valid && res_bus.ready) begin
				if (pending_results.size() == 0) begin
					report_mismatch("unrequested result", -1, int'(res_bus.outcome));
				end else begin
					want = pending_results.pop_front();
					if (res_bus.outcome !== want.outcome)
						report_mismatch("outcome", want.outcome, res_bus.outcome);
					if (res_bus.rom_source !== want.rom_source)
						report_mismatch("rom_source", want.rom_source, res_bus.rom_source);
					if (res_bus.rom_address !== want.rom_address)
						report_mismatch("rom_address", want.rom_address, res_bus.rom_address);
					if (res_bus.ram_data !== want.ram_data)
						report_mismatch("ram_data", want.ram_data, res_bus.ram_data);
				end
			end
			if (acc_bus.valid && acc_bus.ready)
				pending_results.push_back(predict_access(acc_bus.kind, acc_bus.address,
					acc_bus.write_data));
		end
	end

	// Result side: random stalls, plus one long hold-off on request
	initial begin
		int stall_left;
		stall_left    = 0;
		res_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_request) begin
				stall_request = 1'b0;
				stall_left    = LONG_HOLD;
			end
			if (stall_left > 0) begin
				stall_left--;
				res_bus.ready <= 1'b0;
			end else if (rx_idle && $urandom_range(0, 4) == 0) begin
				stall_left    = pick_gap() - 1;
				res_bus.ready <= 1'b0;
			end else begin
				res_bus.ready <= 1'b1;
			end
		end
	end

	// Abandon a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Offer one request and hold it until accepted; call at a falling edge
	task automatic send_access(input logic kind, input logic [ADDR_W-1:0] address,
			input logic [DATA_W-1:0] data);
		int gap;
		gap = (tx_idle && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
		if (gap > 0) begin
			acc_bus.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		acc_bus.valid      <= 1'b1;
		acc_bus.kind       <= kind;
		acc_bus.address    <= address;
		acc_bus.write_data <= data;
		do @(posedge clk); while (!acc_bus.ready);
		@(negedge clk);
	endtask

	// Drop valid and wait until every result is back
	task automatic wait_idle();
		acc_bus.valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// APB write: setup cycle, then access cycle
	task automatic write_register(input logic [1:0] index, input logic [CFG_DW-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {index, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (index)
			REG_BOOTROM_PRESENT: rom_on     = value[0];
			REG_BANKS_FROM_CART: from_cart  = value[0];
			REG_BANK_MASK:       mask_image = value[BANK_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	task automatic configure(input logic present, input logic cart, input logic [7:0] mask);
		wait_idle();
		write_register(REG_BOOTROM_PRESENT, CFG_DW'(present));
		write_register(REG_BANKS_FROM_CART, CFG_DW'(cart));
		write_register(REG_BANK_MASK, CFG_DW'(mask));
	endtask

	// Region edges, fixed area, mirroring, setup byte and bank loads
	task automatic test_memory_map();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		send_access(KIND_READ, 16'h0000, 8'h00);
		send_access(KIND_READ, 16'h03FF, 8'hFF);
		send_access(KIND_READ, 16'h0400, 8'h00);
		send_access(KIND_READ, 16'h3FFF, 8'h00);
		send_access(KIND_READ, 16'h4000, 8'h00);
		send_access(KIND_READ, 16'h7FFF, 8'h00);
		send_access(KIND_READ, 16'h8000, 8'h00);
		send_access(KIND_READ, 16'hBFFF, 8'h00);
		send_access(KIND_WRITE, 16'h0000, 8'h11);
		send_access(KIND_WRITE, 16'hBFFF, 8'h22);
		send_access(KIND_WRITE, 16'hC000, 8'hA5);
		send_access(KIND_READ, 16'hC000, 8'h00);
		send_access(KIND_WRITE, 16'hE000, 8'h5A);
		send_access(KIND_READ, 16'hC000, 8'h00);
		send_access(KIND_READ, 16'hDFFF, 8'h00);
		send_access(KIND_WRITE, 16'hFFFC, 8'h3C);
		send_access(KIND_READ, 16'hDFFC, 8'h00);
		send_access(KIND_WRITE, 16'hFFFD, 8'hFF);
		send_access(KIND_WRITE, 16'hFFFE, 8'h13);
		send_access(KIND_WRITE, 16'hFFFF, 8'h80);
		send_access(KIND_READ, 16'h0400, 8'h00);
		send_access(KIND_READ, 16'h7FFF, 8'h00);
		send_access(KIND_READ, 16'h8000, 8'h00);
		send_access(KIND_READ, 16'hFFFD, 8'h00);
	endtask

	// Hold the result side off while requests keep coming
	task automatic test_output_stall();
		wait_idle();
		tx_idle       = 1'b0;
		rx_idle       = 1'b0;
		stall_request = 1'b1;
		repeat (24)
			send_access(1'($urandom_range(0, 1)), 16'hC000 | 16'($urandom_range(0, 31)),
				8'($urandom));
	endtask

	// Random traffic, mostly well-formed region accesses, under one setting
	task automatic test_random_traffic(input logic present, input logic cart,
			input logic [7:0] mask, input int count, input bit tx_gaps, input bit rx_gaps);
		logic              kind;
		logic [ADDR_W-1:0] address;
		logic [DATA_W-1:0] data;
		logic [ADDR_W-1:0] ram_address;
		configure(present, cart, mask);
		tx_idle = tx_gaps;
		rx_idle = rx_gaps;
		repeat (count) begin
			data = 8'($urandom);
			// Hot RAM bytes in both mirrors so reads see earlier stores
			ram_address = ($urandom_range(0, 1) == 0)
				? (16'hC000 | 16'($urandom_range(0, 1) << 13) | 16'($urandom_range(0, 63)))
				: 16'($urandom_range(16'hC000, 16'hFFFC));
			case ($urandom_range(0, 9))
				0, 1: begin
					kind    = KIND_READ;
					address = 16'($urandom_range(0, 16'hBFFF));
				end
				2: begin
					kind    = KIND_READ;
					address = 16'($urandom_range(0, FIXED_BYTES + 15));
				end
				3, 4: begin
					kind    = KIND_READ;
					address = ram_address;
				end
				5, 6: begin
					kind    = KIND_WRITE;
					address = ram_address;
				end
				7: begin
					kind    = KIND_WRITE;
					address = ADDR_BANK0 + 16'($urandom_range(0, 2));
				end
				default: begin
					kind    = 1'($urandom);
					address = 16'($urandom);
				end
			endcase
			send_access(kind, address, data);
		end
	endtask

	initial begin
		arst_n             = 1'b0;
		psel               = 1'b0;
		penable            = 1'b0;
		pwrite             = 1'b0;
		paddr              = '0;
		pwdata             = '0;
		acc_bus.valid      = 1'b0;
		acc_bus.kind       = KIND_READ;
		acc_bus.address    = '0;
		acc_bus.write_data = '0;
		failures           = 0;
		cycle_count        = 0;
		tx_idle            = 1'b0;
		rx_idle            = 1'b0;
		stall_request      = 1'b0;
		rom_on             = RST_BOOTROM_PRESENT;
		from_cart          = RST_BANKS_FROM_CART;
		mask_image         = RST_BANK_MASK;
		bank_image[0]      = 8'd0;
		bank_image[1]      = 8'd1;
		bank_image[2]      = 8'd2;
		foreach (ram_image[i]) ram_image[i] = '0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_memory_map();
		test_output_stall();
		test_random_traffic(1'b1, 1'b0, 8'd15,  300, 1'b1, 1'b1);
		test_random_traffic(1'b1, 1'b1, 8'd255, 300, 1'b0, 1'b0);
		test_random_traffic(1'b0, 1'b1, 8'd0,   100, 1'b1, 1'b1);
		test_random_traffic(1'b1, 1'b0, 8'd0,   200, 1'b1, 1'b0);
		test_random_traffic(1'b1, 1'b1, 8'($urandom), 350, 1'b0, 1'b1);
		wait_idle();

		if (failures == 0 && pending_results.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
